// File: rtl/tdc_pkg.sv
// Package for the template delimiter checker: word types, codes and constants.
// No dependencies; every other rtl file imports it.
`default_nettype none

package tdc_pkg;

  localparam int LINE_BITS = 24;

  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  // Delimiter characters
  localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_NL     = 8'h0A;  // newline

  typedef enum logic [2:0] {
    MODE_OUTSIDE = 3'd0,
    MODE_OPENED  = 3'd1,
    MODE_RAW     = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_CODE    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_STRAY           = 3'd1,
    ST_OPEN_RAW        = 3'd2,
    ST_OPEN_COMMENT    = 3'd3,
    ST_OPEN_CODE       = 3'd4,
    ST_COMMENT_IN_CODE = 3'd5,
    ST_RAW_IN_CODE     = 3'd6,
    ST_NESTED          = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    status_t              status;
    logic [LINE_BITS-1:0] line_number;
  } out_word_t;

  // Line number from a newline count, held at the maximum
  function automatic logic [LINE_BITS-1:0] line_of(input logic [LINE_BITS-1:0] nl_cnt);
    logic [LINE_BITS-1:0] line;
    if (nl_cnt == LINE_MAX) begin
      line = LINE_MAX;
    end else begin
      line = nl_cnt + {{(LINE_BITS-1){1'b0}}, 1'b1};
    end
    return line;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tdc_scan.sv
// Delimiter scanner: scan state registers and the per-word update logic.
// Depends on tdc_pkg.
`default_nettype none

module tdc_scan
  import tdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire in_word_t  word,
  output logic           fire,
  output out_word_t      res
);

  mode_t                mode_r, mode_nxt;
  logic [7:0]           prev_r, prev_nxt;
  logic [7:0]           prev2_r, prev2_nxt;
  logic                 nested_r, nested_nxt;
  logic [LINE_BITS-1:0] nl_cnt_r, nl_cnt_nxt;
  logic                 err_r, err_nxt;

  logic       pair_close;
  logic       open_pair;
  logic [7:0] b;

  assign b          = word.data_byte;
  assign pair_close = (b == CH_GT) && (prev_r == CH_RPAREN);
  assign open_pair  = (b == CH_LPAREN) && (prev_r == CH_LT);

  always_comb begin
    mode_nxt   = mode_r;
    prev_nxt   = prev_r;
    prev2_nxt  = prev2_r;
    nested_nxt = nested_r;
    nl_cnt_nxt = nl_cnt_r;
    err_nxt    = err_r;
    fire       = 1'b0;
    res.status      = ST_OK;
    res.line_number = line_of(nl_cnt_r);

    if (!err_r) begin
      unique case (mode_r)
        MODE_OUTSIDE: begin
          if (pair_close) begin
            fire       = 1'b1;
            res.status = ST_STRAY;
          end else if (open_pair) begin
            mode_nxt = MODE_OPENED;
          end
        end
        MODE_OPENED: begin
          if (b == CH_GT) begin
            mode_nxt = MODE_RAW;
          end else if (b == CH_STAR) begin
            mode_nxt = MODE_COMMENT;
          end else begin
            mode_nxt   = MODE_CODE;
            nested_nxt = 1'b0;
          end
        end
        MODE_RAW: begin
          if (pair_close && prev2_r == CH_LT) begin
            mode_nxt = MODE_OUTSIDE;
          end
        end
        MODE_COMMENT: begin
          if (pair_close && prev2_r == CH_STAR) begin
            mode_nxt = MODE_OUTSIDE;
          end
        end
        default: begin
          if (pair_close) begin
            priority if (prev2_r == CH_STAR) begin
              fire       = 1'b1;
              res.status = ST_COMMENT_IN_CODE;
            end else if (prev2_r == CH_LT) begin
              fire       = 1'b1;
              res.status = ST_RAW_IN_CODE;
            end else if (nested_r) begin
              fire       = 1'b1;
              res.status = ST_NESTED;
            end else begin
              mode_nxt   = MODE_OUTSIDE;
              nested_nxt = 1'b0;
            end
          end else if (open_pair) begin
            nested_nxt = 1'b1;
          end
        end
      endcase

      prev2_nxt = prev_r;
      prev_nxt  = b;
      if (b == CH_NL && nl_cnt_r != LINE_MAX) begin
        nl_cnt_nxt = nl_cnt_r + {{(LINE_BITS-1){1'b0}}, 1'b1};
      end

      // End of template without an earlier result: report the final line
      if (!fire && word.last_byte) begin
        fire            = 1'b1;
        res.line_number = line_of(nl_cnt_nxt);
        unique case (mode_nxt)
          MODE_OUTSIDE: res.status = ST_OK;
          MODE_RAW:     res.status = ST_OPEN_RAW;
          MODE_COMMENT: res.status = ST_OPEN_COMMENT;
          default:      res.status = ST_OPEN_CODE;
        endcase
      end
      if (fire) begin
        err_nxt = 1'b1;
      end
    end

    // Last word re-arms everything for the next template
    if (word.last_byte) begin
      mode_nxt   = MODE_OUTSIDE;
      prev_nxt   = '0;
      prev2_nxt  = '0;
      nested_nxt = 1'b0;
      nl_cnt_nxt = '0;
      err_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_OUTSIDE;
      prev_r   <= '0;
      prev2_r  <= '0;
      nested_r <= 1'b0;
      nl_cnt_r <= '0;
      err_r    <= 1'b0;
    end else if (adv) begin
      mode_r   <= mode_nxt;
      prev_r   <= prev_nxt;
      prev2_r  <= prev2_nxt;
      nested_r <= nested_nxt;
      nl_cnt_r <= nl_cnt_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tdc_out_reg.sv
// Result register with valid/ready handshake on the output side.
// Depends on tdc_pkg.
`default_nettype none

module tdc_out_reg
  import tdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire out_word_t res,
  output logic           free,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  logic      valid_r, valid_nxt;
  out_word_t data_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

endmodule

`default_nettype wire

// File: rtl/template_delimiter_checker_unit.sv
// Template delimiter checker, top level: input register, scanner, result register.
// A word in the input register loads its result (if any) into the result register when
// it advances. Throughput: one word per cycle while the result slot is free.
// Stall: a result waiting on out_ready holds the input register; in_ready drops once it is full.
// Reset (rst_n low, synchronous): both pipeline registers empty, scan state cleared.
// Depends on tdc_pkg, tdc_scan and tdc_out_reg.
`default_nettype none

module template_delimiter_checker_unit
  import tdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  // Input stage: holds one word until the scanner can consume it
  logic      s1_valid_r, s1_valid_nxt;
  in_word_t  s1_word_r;

  logic      out_free;
  logic      adv;
  logic      fire;
  out_word_t res;

  // Advance the input word into the scan state when the result slot is free
  // (empty, or being drained this cycle). Words that give no result just drop.
  assign adv      = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_data;
    end
  end

  tdc_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .word  (s1_word_r),
    .fire  (fire),
    .res   (res)
  );

  // Load the result register only when the scanner reports
  tdc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && fire),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: bench/tdc_report_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the template delimiter checker: watches both channels, predicts the
// report for each template from the accepted bytes and compares. Needs tdc_pkg.
module tdc_report_checker
  import tdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        fail_count,
  output int        reports_due,
  output int        reports_made,
  output int        reports_seen
);

  localparam int SHOWN_FAILS = 10;

  mode_t                mode_q;
  logic [7:0]           last_ch;
  logic [7:0]           older_ch;
  logic                 nest_flag;
  logic                 err_flag;
  logic [LINE_BITS-1:0] nl_total;
  out_word_t            due_q[$];

  function automatic logic [LINE_BITS-1:0] line_now();
    return (nl_total == LINE_MAX) ? LINE_MAX : nl_total + 1'b1;
  endfunction

  task automatic clear_scan();
    mode_q    = MODE_OUTSIDE;
    last_ch   = 8'h00;
    older_ch  = 8'h00;
    nest_flag = 1'b0;
    err_flag  = 1'b0;
    nl_total  = '0;
  endtask

  task automatic note_fault(input string msg);
    fail_count++;
    if (fail_count <= SHOWN_FAILS) $display("[%0t] report mismatch: %s", $time, msg);
  endtask

  // Advance the scan by one byte; queue the report it causes, if any
  task automatic scan_byte(input in_word_t w);
    logic                 hit;
    logic                 closer;
    status_t              code;
    logic [LINE_BITS-1:0] line;
    out_word_t            rep;
    hit  = 1'b0;
    code = ST_OK;
    line = '0;
    if (!err_flag) begin
      closer = (w.data_byte == CH_GT) && (last_ch == CH_RPAREN);
      case (mode_q)
        MODE_OUTSIDE: begin
          if (closer) begin
            hit  = 1'b1;
            code = ST_STRAY;
            line = line_now();
          end else if (w.data_byte == CH_LPAREN && last_ch == CH_LT) begin
            mode_q = MODE_OPENED;
          end
        end
        MODE_OPENED: begin
          if (w.data_byte == CH_GT) begin
            mode_q = MODE_RAW;
          end else if (w.data_byte == CH_STAR) begin
            mode_q = MODE_COMMENT;
          end else begin
            mode_q    = MODE_CODE;
            nest_flag = 1'b0;
          end
        end
        MODE_RAW: begin
          if (closer && older_ch == CH_LT) mode_q = MODE_OUTSIDE;
        end
        MODE_COMMENT: begin
          if (closer && older_ch == CH_STAR) mode_q = MODE_OUTSIDE;
        end
        default: begin
          if (closer) begin
            if (older_ch == CH_STAR) begin
              hit  = 1'b1;
              code = ST_COMMENT_IN_CODE;
            end else if (older_ch == CH_LT) begin
              hit  = 1'b1;
              code = ST_RAW_IN_CODE;
            end else if (nest_flag) begin
              hit  = 1'b1;
              code = ST_NESTED;
            end else begin
              mode_q    = MODE_OUTSIDE;
              nest_flag = 1'b0;
            end
            if (hit) line = line_now();
          end else if (w.data_byte == CH_LPAREN && last_ch == CH_LT) begin
            nest_flag = 1'b1;
          end
        end
      endcase

      older_ch = last_ch;
      last_ch  = w.data_byte;
      if (w.data_byte == CH_NL && nl_total != LINE_MAX) nl_total = nl_total + 1'b1;

      if (!hit && w.last_byte) begin
        hit  = 1'b1;
        line = line_now();
        case (mode_q)
          MODE_OUTSIDE: code = ST_OK;
          MODE_RAW:     code = ST_OPEN_RAW;
          MODE_COMMENT: code = ST_OPEN_COMMENT;
          default:      code = ST_OPEN_CODE;
        endcase
      end
      if (hit) err_flag = 1'b1;
    end

    if (hit) begin
      rep.status      = code;
      rep.line_number = line;
      due_q = {due_q, rep};
      reports_made++;
    end
    if (w.last_byte) clear_scan();
  endtask

  task automatic check_report(input out_word_t got);
    out_word_t want;
    reports_seen++;
    if (due_q.size() == 0) begin
      note_fault($sformatf("report with nothing due: status %0d line %0d",
                           got.status, got.line_number));
    end else begin
      want = due_q.pop_front();
      if (got.status !== want.status || got.line_number !== want.line_number) begin
        note_fault($sformatf("got status %0d line %0d, expected status %0d line %0d",
                             got.status, got.line_number, want.status, want.line_number));
      end
    end
  endtask

  // Compare before scanning: a report never leaves in the cycle its byte enters
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      due_q.delete();
      fail_count   = 0;
      reports_made = 0;
      reports_seen = 0;
    end else begin
      if (out_valid && out_ready) check_report(out_data);
      if (in_valid && in_ready) scan_byte(in_data);
    end
    reports_due = due_q.size();
  end

endmodule

// File: bench/template_delimiter_checker_unit_test.sv
`timescale 1ns / 100ps
// Top of the template delimiter checker bench: clock, reset, template stimulus, receiver
// stalls and the verdict. Needs tdc_pkg, the block and tdc_report_checker.
module template_delimiter_checker_unit_test
  import tdc_pkg::*;
();

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 7;
  localparam int WORD_TARGET  = 450;   // template bytes to send in all before the random part stops
  localparam int PHASE_LEN    = 6;     // templates per idle/stall phase
  localparam int PRESSURE_AT  = 26;    // template that starts under a long hold-off
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 4000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {
    SEG_TEXT, SEG_RAW, SEG_COMMENT, SEG_CODE,
    SEG_CODE_STAR, SEG_CODE_LT, SEG_CODE_NEST, SEG_STRAY
  } seg_kind_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  int fail_count;
  int reports_due;
  int reports_made;
  int reports_seen;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int holds_asked    = 0;
  int holds_done     = 0;
  int quiet_cycles   = 0;
  int words_sent     = 0;
  int templates_sent = 0;

  logic [7:0] tmpl_q[$];   // bytes of the template being built

  always #(CLK_PERIOD / 2) clk = ~clk;

  template_delimiter_checker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  tdc_report_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .reports_due  (reports_due),
    .reports_made (reports_made),
    .reports_seen (reports_seen)
  );

  // Receiver: stall at random each cycle; on request hold off for a long stretch so the
  // block fills up and drops in_ready while the sender keeps offering words.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        repeat (LONG_HOLD) begin
          out_ready <= 1'b0;
          @(negedge clk);
        end
        holds_done++;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("timeout: no word accepted for %0d cycles, %0d reports still due",
                 QUIET_LIMIT, reports_due);
        $display("template_delimiter_checker_unit: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Mostly letters, some newlines, now and then any byte at all
  function automatic logic [7:0] filler_byte();
    int roll;
    roll = $urandom_range(99);
    if (roll < 12) return CH_NL;
    if (roll < 22) return 8'($urandom_range(255));
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  task automatic add_byte(input logic [7:0] ch);
    tmpl_q = {tmpl_q, ch};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic push_body();
    repeat ($urandom_range(4)) add_byte(filler_byte());
  endtask

  // Append one piece of template: plain text, a block, a broken block or a stray closer
  task automatic add_segment();
    int         roll;
    seg_kind_t  kind;
    logic [7:0] lead;
    roll = $urandom_range(99);
    if (roll < 20)      kind = SEG_TEXT;
    else if (roll < 38) kind = SEG_RAW;
    else if (roll < 56) kind = SEG_COMMENT;
    else if (roll < 80) kind = SEG_CODE;
    else if (roll < 85) kind = SEG_CODE_STAR;
    else if (roll < 90) kind = SEG_CODE_LT;
    else if (roll < 95) kind = SEG_CODE_NEST;
    else                kind = SEG_STRAY;
    // first byte of a code block: never '>' or '*', which would pick raw or comment
    case ($urandom_range(4))
      0:       lead = CH_LT;
      1:       lead = CH_NL;
      default: lead = 8'h61 + 8'($urandom_range(25));
    endcase
    case (kind)
      SEG_TEXT: begin
        repeat ($urandom_range(4, 1)) add_byte(filler_byte());
      end
      SEG_RAW: begin
        push_text("<(>");
        push_body();
        push_text("<)>");
      end
      SEG_COMMENT: begin
        push_text("<(*");
        push_body();
        push_text("*)>");
      end
      SEG_STRAY: push_text(")>");
      default: begin
        push_text("<(");
        add_byte(lead);
        push_body();
        case (kind)
          SEG_CODE_STAR: push_text("*)>");
          SEG_CODE_LT:   push_text("<)>");
          SEG_CODE_NEST: begin
            push_text("<(");
            push_body();
            push_text(")>");
          end
          default:       push_text(")>");
        endcase
      end
    endcase
  endtask

  // Mostly well-formed sequences of blocks; some cut short, some pure delimiter noise
  task automatic build_template();
    int roll;
    roll = $urandom_range(99);
    if (roll < 18) begin
      repeat ($urandom_range(12, 1)) begin
        case ($urandom_range(6))
          0:       add_byte(CH_LT);
          1:       add_byte(CH_LPAREN);
          2:       add_byte(CH_RPAREN);
          3:       add_byte(CH_GT);
          4:       add_byte(CH_STAR);
          5:       add_byte(CH_NL);
          default: add_byte(filler_byte());
        endcase
      end
    end else begin
      repeat ($urandom_range(3, 1)) add_segment();
      // drop the tail so a block may be left open at the last byte
      if (roll >= 88) begin
        repeat ($urandom_range(3, 1)) begin
          if (tmpl_q.size() > 1) void'(tmpl_q.pop_back());
        end
      end
    end
  endtask

  // Offer one word at a falling edge, after an optional idle gap; hold it until taken
  task automatic send_word(input logic [7:0] ch, input logic tail);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data.data_byte <= ch;
    in_data.last_byte <= tail;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Send the built template with the last flag on its final byte, then clear it
  task automatic send_template();
    foreach (tmpl_q[i]) send_word(tmpl_q[i], i == tmpl_q.size() - 1);
    tmpl_q.delete();
    templates_sent++;
  endtask

  initial begin
    int phase;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: one template per outcome, plus the corner cases of the scan
    push_text("<(*)>");             // empty comment: the '*' also starts the closer
    send_template();
    push_text(")>");                // stray closer, then a byte that is ignored
    add_byte(8'hFF);
    send_template();
    push_text("<(");                // opener as last byte: still counts as code
    send_template();
    push_text("<(>");               // raw block left open
    add_byte(8'h00);
    send_template();
    push_text("<(*");               // comment block left open
    send_template();
    push_text("<(\n*)>");           // comment closer ends code, on line two
    send_template();
    push_text("<(<)>");             // raw closer ends code
    send_template();
    push_text("<(<()>");            // opener nested inside code
    send_template();

    // Random: rotate the idle/stall mix every few templates
    while (words_sent < WORD_TARGET) begin
      phase = (templates_sent / PHASE_LEN) % 4;
      case (phase)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 52; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 52; end
        default: begin send_gap_pct = 30; recv_stall_pct = 30; end
      endcase
      if (templates_sent == PRESSURE_AT) holds_asked++;
      build_template();
      send_template();
    end
    in_valid <= 1'b0;

    // Drain: wait for every report, then keep watching for anything unexpected
    while (reports_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d template bytes in %0d templates, %0d of %0d reports checked,",
             words_sent, templates_sent, reports_seen, reports_made);
    $display("under rotating sender gaps and receiver stalls with one long hold-off");
    if (fail_count == 0 && reports_due == 0) begin
      $display("template_delimiter_checker_unit: match");
    end else begin
      $display("template_delimiter_checker_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tdc_pkg.sv
rtl/tdc_scan.sv
rtl/tdc_out_reg.sv
rtl/template_delimiter_checker_unit.sv
bench/tdc_report_checker.sv
bench/template_delimiter_checker_unit_test.sv
